// ===== src/ket_pkg.sv =====
// ----------------------------------------------------------------------------
// ket_pkg: shared types and helpers
// Constants, record types, result states and saturating arithmetic for the
// kinetic energy tensor accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package ket_pkg;

  localparam int TERM_W    = 48;
  localparam int SUM_W     = 64;
  localparam int N_COMP    = 6;
  localparam int CFG_IDX_W = 8;
  localparam int IN_W      = 88;
  localparam int OUT_W     = 512;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

  localparam logic [31:0] ENERGY_SCALE_RESET = 32'd5132609;
  localparam logic [31:0] TEMP_SCALE_RESET   = 32'd0;

  localparam logic [CFG_IDX_W-1:0] REG_ENERGY_SCALE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_SCALE   = 8'd1;

  // Component order: xx, yy, zz, xy, yz, zx.
  typedef struct packed {
    logic                           last;
    logic [N_COMP-1:0][TERM_W-1:0]  term;
  } term_t;

  typedef struct packed {
    logic [N_COMP-1:0][SUM_W-1:0] sum;
  } snap_t;

  typedef enum logic [2:0] {
    RS_IDLE,
    RS_TOT_A,
    RS_TOT_B,
    RS_MUL_LO,
    RS_MUL_HI,
    RS_FINAL
  } res_state_t;

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                               input logic [SUM_W-1:0] b);
    logic [SUM_W:0] s;
    s = {a[SUM_W-1], a} + {b[SUM_W-1], b};
    if (s[SUM_W] != s[SUM_W-1]) begin
      if (s[SUM_W]) begin
        return {1'b1, {(SUM_W-1){1'b0}}};
      end else begin
        return {1'b0, {(SUM_W-1){1'b1}}};
      end
    end
    return s[SUM_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== src/ket_front.sv =====
// ----------------------------------------------------------------------------
// ket_front: input stage and multiplier pipeline
// Takes atom requests, forms the mass weight and the six velocity products,
// and scales them into tensor terms over three register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module ket_front (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_tvalid,
  output logic                         in_tready,
  input  wire logic [ket_pkg::IN_W-1:0] in_tdata,
  input  wire logic                    in_tlast,
  input  wire logic [31:0]             energy_scale,
  input  wire logic                    fifo_full,
  output logic                         push,
  output ket_pkg::term_t               push_data
);

  localparam int NC = ket_pkg::N_COMP;
  localparam int TW = ket_pkg::TERM_W;

  logic               en;
  logic [15:0]        mass;
  logic signed [23:0] vel [3];
  logic [47:0]        wprod;

  logic               s1_valid_r, s2_valid_r, s3_valid_r;
  logic               s1_last_r, s2_last_r, s3_last_r;
  logic [31:0]        w_r, w_nxt;
  logic signed [47:0] p_r [NC];
  logic signed [47:0] p_nxt [NC];
  logic signed [63:0] hi_r [NC];
  logic signed [63:0] hi_nxt [NC];
  logic signed [63:0] lo_r [NC];
  logic signed [63:0] lo_nxt [NC];
  logic [79:0]        sum80 [NC];
  logic [TW-1:0]      term_r [NC];
  logic [TW-1:0]      term_nxt [NC];

  assign en        = !(s3_valid_r && fifo_full);
  assign in_tready = en;
  assign push      = s3_valid_r && en;

  always_comb begin
    mass   = in_tdata[15:0];
    vel[0] = $signed(in_tdata[39:16]);
    vel[1] = $signed(in_tdata[63:40]);
    vel[2] = $signed(in_tdata[87:64]);
    wprod  = 48'(mass) * 48'(energy_scale);
    w_nxt  = wprod[47:16];
    p_nxt[0] = vel[0] * vel[0];
    p_nxt[1] = vel[1] * vel[1];
    p_nxt[2] = vel[2] * vel[2];
    p_nxt[3] = vel[0] * vel[1];
    p_nxt[4] = vel[1] * vel[2];
    p_nxt[5] = vel[2] * vel[0];
    for (int k = 0; k < NC; k++) begin
      hi_nxt[k]   = $signed({1'b0, w_r[31:16]}) * p_r[k];
      lo_nxt[k]   = $signed({1'b0, w_r[15:0]}) * p_r[k];
      sum80[k]    = {hi_r[k], 16'h0000} + {{16{lo_r[k][63]}}, lo_r[k]};
      term_nxt[k] = sum80[k][79:32];
    end
  end

  always_comb begin
    push_data.last = s3_last_r;
    for (int k = 0; k < NC; k++) begin
      push_data.term[k] = term_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= in_tvalid;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_last_r <= in_tlast;
      s2_last_r <= s1_last_r;
      s3_last_r <= s2_last_r;
      w_r       <= w_nxt;
      for (int k = 0; k < NC; k++) begin
        p_r[k]    <= p_nxt[k];
        hi_r[k]   <= hi_nxt[k];
        lo_r[k]   <= lo_nxt[k];
        term_r[k] <= term_nxt[k];
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/ket_fifo.sv =====
// ----------------------------------------------------------------------------
// ket_fifo: term queue
// Short first-in first-out queue of tensor term records between the
// multiplier pipeline and the accumulators.
// ----------------------------------------------------------------------------
`default_nettype none

module ket_fifo (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire ket_pkg::term_t push_data,
  output logic                full,
  input  wire logic           pop,
  output logic                empty,
  output ket_pkg::term_t      head
);

  localparam int D  = ket_pkg::FIFO_DEPTH;
  localparam int PW = ket_pkg::FIFO_PTR_W;

  ket_pkg::term_t mem_r [D];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]    count_r, count_nxt;

  assign full  = (count_r == (PW+1)'(D));
  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== src/ket_back.sv =====
// ----------------------------------------------------------------------------
// ket_back: tensor accumulators
// Pops term records, adds them into six saturating sums and hands a snapshot
// of the sums to the result unit on the final atom of a set.
// ----------------------------------------------------------------------------
`default_nettype none

module ket_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           empty,
  input  wire ket_pkg::term_t head,
  output logic                pop,
  output logic                snap_valid,
  input  wire logic           snap_ready,
  output ket_pkg::snap_t      snap
);

  localparam int NC = ket_pkg::N_COMP;
  localparam int SW = ket_pkg::SUM_W;
  localparam int TW = ket_pkg::TERM_W;

  logic [SW-1:0] sum_r [NC];
  logic [SW-1:0] sum_nxt [NC];
  logic [SW-1:0] acc [NC];

  assign pop        = !empty && (!head.last || snap_ready);
  assign snap_valid = pop && head.last;

  always_comb begin
    for (int k = 0; k < NC; k++) begin
      acc[k] = ket_pkg::sat_add(sum_r[k], {{(SW-TW){head.term[k][TW-1]}}, head.term[k]});
      snap.sum[k] = acc[k];
      if (!pop) begin
        sum_nxt[k] = sum_r[k];
      end else if (head.last) begin
        sum_nxt[k] = '0;
      end else begin
        sum_nxt[k] = acc[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NC; k++) begin
        sum_r[k] <= '0;
      end
    end else begin
      for (int k = 0; k < NC; k++) begin
        sum_r[k] <= sum_nxt[k];
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/ket_result.sv =====
// ----------------------------------------------------------------------------
// ket_result: trace and temperature unit
// Forms the saturated trace and the temperature from a snapshot of the sums
// in a short sequence, and holds the finished result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ket_result (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      snap_valid,
  output logic                           snap_ready,
  input  wire ket_pkg::snap_t            snap,
  input  wire logic [31:0]               temperature_scale,
  output logic                           out_tvalid,
  input  wire logic                      out_tready,
  output logic [ket_pkg::OUT_W-1:0]      out_tdata
);

  localparam int SW = ket_pkg::SUM_W;

  ket_pkg::res_state_t state_r, state_nxt;
  ket_pkg::snap_t      snap_r, snap_nxt;
  logic [SW-1:0]       total_r, total_nxt;
  logic [63:0]         plo_r, plo_nxt;
  logic [62:0]         phi_r, phi_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [ket_pkg::OUT_W-1:0] out_data_r, out_data_nxt;
  logic [62:0]         tpos;
  logic [94:0]         full_prod;
  logic [78:0]         quot;
  logic [62:0]         temp;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    tpos      = total_r[SW-1] ? 63'd0 : total_r[62:0];
    full_prod = {phi_r, 32'h0000_0000} + {31'h0, plo_r};
    quot      = full_prod[94:16];
    temp      = (quot[78:63] != '0) ? {63{1'b1}} : quot[62:0];

    state_nxt     = state_r;
    snap_nxt      = snap_r;
    total_nxt     = total_r;
    plo_nxt       = plo_r;
    phi_nxt       = phi_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_tready;
    snap_ready    = 1'b0;

    case (state_r)
      ket_pkg::RS_IDLE: begin
        snap_ready = 1'b1;
        if (snap_valid) begin
          snap_nxt  = snap;
          state_nxt = ket_pkg::RS_TOT_A;
        end
      end
      ket_pkg::RS_TOT_A: begin
        total_nxt = ket_pkg::sat_add(snap_r.sum[0], snap_r.sum[1]);
        state_nxt = ket_pkg::RS_TOT_B;
      end
      ket_pkg::RS_TOT_B: begin
        total_nxt = ket_pkg::sat_add(total_r, snap_r.sum[2]);
        state_nxt = ket_pkg::RS_MUL_LO;
      end
      ket_pkg::RS_MUL_LO: begin
        plo_nxt   = 64'(tpos[31:0]) * 64'(temperature_scale);
        state_nxt = ket_pkg::RS_MUL_HI;
      end
      ket_pkg::RS_MUL_HI: begin
        phi_nxt   = 63'(tpos[62:32]) * 63'(temperature_scale);
        state_nxt = ket_pkg::RS_FINAL;
      end
      ket_pkg::RS_FINAL: begin
        if (!out_valid_r || out_tready) begin
          out_data_nxt  = {1'b0, temp, total_r, snap_r.sum[5], snap_r.sum[4],
                           snap_r.sum[3], snap_r.sum[2], snap_r.sum[1], snap_r.sum[0]};
          out_valid_nxt = 1'b1;
          state_nxt     = ket_pkg::RS_IDLE;
        end
      end
      default: begin
        state_nxt = ket_pkg::RS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ket_pkg::RS_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    snap_r     <= snap_nxt;
    total_r    <= total_nxt;
    plo_r      <= plo_nxt;
    phi_r      <= phi_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

`default_nettype wire

// ===== src/kinetic_energy_tensor_accumulator_top.sv =====
// ----------------------------------------------------------------------------
// kinetic_energy_tensor_accumulator_top: kinetic energy tensor accumulator
// Accepts one atom request per cycle while the term queue has room,
// accumulates the six kinetic tensor sums and on the final atom of a set
// returns the sums, their trace and a temperature. The multiplier pipeline
// and the accumulators take one atom per cycle; a result holds the trace and
// temperature unit through its states, and a closing atom waits while that
// unit is busy. A final atom passes the multiplier stages, the queue, the
// snapshot register, the trace and temperature states and the output register.
// Synchronous active-low reset clears the sums, the queue and the control
// state, and loads the configuration registers with their defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module kinetic_energy_tensor_accumulator_top (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  // atom_mass[15:0], vel_x[39:16], vel_y[63:40], vel_z[87:64]
  input  wire logic [ket_pkg::IN_W-1:0]       in_tdata,
  input  wire logic                           in_tlast,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  // ek_xx[63:0], ek_yy[127:64], ek_zz[191:128], ek_xy[255:192],
  // ek_yz[319:256], ek_zx[383:320], ek_total[447:384], temperature[510:448]
  output logic [ket_pkg::OUT_W-1:0]           out_tdata,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [ket_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [31:0]                    cfg_data
);

  logic [31:0]    energy_scale_r, energy_scale_nxt;
  logic [31:0]    temp_scale_r, temp_scale_nxt;
  logic           fifo_full, fifo_empty, push, pop;
  ket_pkg::term_t push_data, head;
  logic           snap_valid, snap_ready;
  ket_pkg::snap_t snap;

  assign cfg_ready = 1'b1;

  always_comb begin
    energy_scale_nxt = energy_scale_r;
    temp_scale_nxt   = temp_scale_r;
    if (cfg_valid) begin
      case (cfg_index)
        ket_pkg::REG_ENERGY_SCALE: energy_scale_nxt = cfg_data;
        ket_pkg::REG_TEMP_SCALE:   temp_scale_nxt   = cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      energy_scale_r <= ket_pkg::ENERGY_SCALE_RESET;
      temp_scale_r   <= ket_pkg::TEMP_SCALE_RESET;
    end else begin
      energy_scale_r <= energy_scale_nxt;
      temp_scale_r   <= temp_scale_nxt;
    end
  end

  ket_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tlast     (in_tlast),
    .energy_scale (energy_scale_r),
    .fifo_full    (fifo_full),
    .push         (push),
    .push_data    (push_data)
  );

  ket_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (fifo_full),
    .pop       (pop),
    .empty     (fifo_empty),
    .head      (head)
  );

  ket_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .empty      (fifo_empty),
    .head       (head),
    .pop        (pop),
    .snap_valid (snap_valid),
    .snap_ready (snap_ready),
    .snap       (snap)
  );

  ket_result u_result (
    .clk               (clk),
    .rst_n             (rst_n),
    .snap_valid        (snap_valid),
    .snap_ready        (snap_ready),
    .snap              (snap),
    .temperature_scale (temp_scale_r),
    .out_tvalid        (out_tvalid),
    .out_tready        (out_tready),
    .out_tdata         (out_tdata)
  );

endmodule

`default_nettype wire

// ===== dv/ke_tensor_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ke_tensor_checker: kinetic energy report checker
// Watches the atom, result and register channels of the kinetic energy tensor
// accumulator. It keeps its own copy of the scales and the six tensor sums,
// works out each energy report when an atom closes a set, and compares every
// returned report field by field with the oldest one still due.
// ----------------------------------------------------------------------------

module ke_tensor_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  input  logic                              in_tready,
  input  logic [ket_pkg::IN_W-1:0]          in_tdata,
  input  logic                              in_tlast,
  input  logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic [ket_pkg::OUT_W-1:0]         out_tdata,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [ket_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [31:0]                       cfg_data,
  output int                                reports_pending,
  output int                                reports_checked,
  output int                                mismatches
);

  localparam logic signed [64:0] WIDE_MAX = 65'sd9223372036854775807;
  localparam logic signed [64:0] WIDE_MIN = -65'sd9223372036854775808;

  typedef struct packed {
    logic signed [63:0] xx;
    logic signed [63:0] yy;
    logic signed [63:0] zz;
    logic signed [63:0] xy;
    logic signed [63:0] yz;
    logic signed [63:0] zx;
    logic signed [63:0] total;
    logic [62:0]        temperature;
  } energy_report_t;

  logic [31:0]        energy_scale_q;
  logic [31:0]        temp_scale_q;
  logic signed [63:0] tensor_sum [ket_pkg::N_COMP];
  energy_report_t     reports_due [$];

  function automatic logic signed [63:0] clamp_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic signed [64:0] s;
    s = a + b;
    if (s > WIDE_MAX) begin
      return WIDE_MAX[63:0];
    end else if (s < WIDE_MIN) begin
      return WIDE_MIN[63:0];
    end
    return s[63:0];
  endfunction

  // Exact product, then a floor division by 2^32.
  function automatic logic signed [63:0] weighted_term(input logic [31:0] w,
                                                       input logic signed [47:0] p);
    logic signed [95:0] full;
    full = $signed({1'b0, w}) * p;
    return full[95:32];
  endfunction

  function automatic logic [62:0] temperature_of(input logic signed [63:0] total,
                                                 input logic [31:0] scale);
    logic [127:0] full;
    logic [127:0] scaled;
    if (total <= 0) begin
      return '0;
    end
    full = {64'd0, total} * {96'd0, scale};
    scaled = full >> 16;
    if (scaled > 128'h7FFF_FFFF_FFFF_FFFF) begin
      return '1;
    end
    return scaled[62:0];
  endfunction

  task automatic absorb_atom(input logic [15:0] mass, input logic signed [23:0] vx,
                             input logic signed [23:0] vy, input logic signed [23:0] vz,
                             input logic last);
    logic [47:0]        scaled_mass;
    logic [31:0]        w;
    logic signed [47:0] prod [ket_pkg::N_COMP];
    energy_report_t     rep;
    scaled_mass = mass * energy_scale_q;
    w = scaled_mass[47:16];
    prod[0] = vx * vx;
    prod[1] = vy * vy;
    prod[2] = vz * vz;
    prod[3] = vx * vy;
    prod[4] = vy * vz;
    prod[5] = vz * vx;
    for (int c = 0; c < ket_pkg::N_COMP; c++) begin
      tensor_sum[c] = clamp_add(tensor_sum[c], weighted_term(w, prod[c]));
    end
    if (last) begin
      rep.xx = tensor_sum[0];
      rep.yy = tensor_sum[1];
      rep.zz = tensor_sum[2];
      rep.xy = tensor_sum[3];
      rep.yz = tensor_sum[4];
      rep.zx = tensor_sum[5];
      rep.total = clamp_add(clamp_add(tensor_sum[0], tensor_sum[1]), tensor_sum[2]);
      rep.temperature = temperature_of(rep.total, temp_scale_q);
      reports_due.push_back(rep);
      for (int c = 0; c < ket_pkg::N_COMP; c++) begin
        tensor_sum[c] = '0;
      end
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%t: %s mismatch, expected %h, got %h", $time, name, want, got);
    end
  endtask

  task automatic compare_report(input logic [ket_pkg::OUT_W-1:0] data);
    energy_report_t want;
    if (reports_due.size() == 0) begin
      mismatches++;
      $display("%t: result with none due, expected nothing, got %h", $time, data);
    end else begin
      want = reports_due.pop_front();
      reports_checked++;
      check_field("ek_xx", want.xx, data[63:0]);
      check_field("ek_yy", want.yy, data[127:64]);
      check_field("ek_zz", want.zz, data[191:128]);
      check_field("ek_xy", want.xy, data[255:192]);
      check_field("ek_yz", want.yz, data[319:256]);
      check_field("ek_zx", want.zx, data[383:320]);
      check_field("ek_total", want.total, data[447:384]);
      check_field("temperature", {1'b0, want.temperature}, {1'b0, data[510:448]});
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      energy_scale_q = ket_pkg::ENERGY_SCALE_RESET;
      temp_scale_q = ket_pkg::TEMP_SCALE_RESET;
      for (int c = 0; c < ket_pkg::N_COMP; c++) begin
        tensor_sum[c] = '0;
      end
      reports_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == ket_pkg::REG_ENERGY_SCALE) begin
          energy_scale_q = cfg_data;
        end else if (cfg_index == ket_pkg::REG_TEMP_SCALE) begin
          temp_scale_q = cfg_data;
        end
      end
      if (out_tvalid && out_tready) begin
        compare_report(out_tdata);
      end
      if (in_tvalid && in_tready) begin
        absorb_atom(in_tdata[15:0], in_tdata[39:16], in_tdata[63:40], in_tdata[87:64],
                    in_tlast);
      end
    end
    reports_pending <= reports_due.size();
  end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: kinetic energy tensor accumulator testbench
// Drives atom requests and scale register writes into the accumulator with
// random gaps and result stalls. Directed sets cover the field extremes, the
// rounding of tiny negative terms, a saturated temperature and a long run of
// full-scale atoms; random sets follow under several scale settings. A
// separate checker predicts and compares every report.
// ----------------------------------------------------------------------------

module tb;

  localparam int CYCLE_LIMIT    = 1_000_000;
  localparam int DRAIN_CYCLES   = 24;
  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_ATOMS    = 140;
  localparam int LONG_SET_ATOMS = 32;

  logic                           clk;
  logic                           rst_n = 1'b0;
  logic                           in_tvalid = 1'b0;
  logic                           in_tready;
  logic [ket_pkg::IN_W-1:0]       in_tdata = '0;
  logic                           in_tlast = 1'b0;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [ket_pkg::OUT_W-1:0]      out_tdata;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [ket_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [31:0]                    cfg_data = '0;

  int reports_pending;
  int reports_checked;
  int mismatches;
  int cycle_count = 0;
  int ready_hold = 0;
  int atoms_sent = 0;
  int sets_sent = 0;
  int settings_used = 1;
  bit calm = 1'b0;

  kinetic_energy_tensor_accumulator_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  ke_tensor_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tlast        (in_tlast),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .reports_pending (reports_pending),
    .reports_checked (reports_checked),
    .mismatches      (mismatches)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL kinetic_energy_tensor_accumulator_top");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end else if (r < 98) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      ready_hold <= pick_gap();
    end
  end

  function automatic logic [15:0] draw_mass();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2, 3: return 16'($urandom_range(0, 1023));
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic logic [23:0] draw_velocity();
    case ($urandom_range(0, 11))
      0: return 24'h800000;
      1: return 24'h7FFFFF;
      2: return 24'h000000;
      3, 4: return 24'(int'($urandom_range(0, 8191)) - 4096);
      default: return 24'($urandom());
    endcase
  endfunction

  function automatic int draw_set_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      return $urandom_range(1, 6);
    end else if (r < 95) begin
      return $urandom_range(7, 16);
    end
    return $urandom_range(17, 40);
  endfunction

  task automatic send_atom(input logic [15:0] mass, input logic [23:0] vx,
                           input logic [23:0] vy, input logic [23:0] vz, input logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {vz, vy, vx, mass};
    in_tlast <= last;
    do @(posedge clk); while (!in_tready);
    atoms_sent++;
    if (last) begin
      sets_sent++;
    end
  endtask

  task automatic send_random_set(input int len);
    for (int i = 0; i < len; i++) begin
      send_atom(draw_mass(), draw_velocity(), draw_velocity(), draw_velocity(), i == len - 1);
    end
  endtask

  // Waits for every report still due, then lets the pipeline empty of
  // atoms that closed no set.
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (reports_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic program_scales(input logic [31:0] e, input logic [31:0] t, input bit stray);
    logic [ket_pkg::CFG_IDX_W-1:0] idx [3];
    logic [31:0]                   val [3];
    int                            n;
    n = 0;
    if (stray) begin
      idx[n] = ket_pkg::CFG_IDX_W'($urandom_range(ket_pkg::REG_TEMP_SCALE + 1, 255));
      val[n] = $urandom();
      n++;
    end
    idx[n] = ket_pkg::REG_ENERGY_SCALE;
    val[n] = e;
    n++;
    idx[n] = ket_pkg::REG_TEMP_SCALE;
    val[n] = t;
    n++;
    for (int k = 0; k < n; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data <= val[k];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  initial begin
    int          n;
    int          len;
    logic [31:0] e;
    logic [31:0] t;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_atom(16'h0000, 24'h7FFFFF, 24'h800000, 24'h123456, 1'b1);
    send_atom(16'hFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 1'b1);
    send_atom(16'hFFFF, 24'h800000, 24'h800000, 24'h800000, 1'b1);
    send_atom(16'hFFFF, 24'h800000, 24'h7FFFFF, 24'h800000, 1'b1);
    send_atom(16'h0001, 24'h000001, 24'hFFFFFF, 24'h000001, 1'b1);
    send_atom(16'h8000, 24'h000000, 24'h000000, 24'h000000, 1'b1);
    send_atom(16'h0100, 24'h001000, 24'hFFF000, 24'h000800, 1'b0);
    send_atom(16'h0C00, 24'hFFE000, 24'h002000, 24'hFFFC00, 1'b0);
    send_random_set(4);
    settle();

    program_scales(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_atom(16'hFFFF, 24'h800000, 24'h800000, 24'h800000, 1'b1);
    send_atom(16'h0100, 24'h000010, 24'hFFFFF0, 24'h000010, 1'b1);
    send_random_set(3);
    settle();

    program_scales(32'd0, 32'h0001_0000, 1'b0);
    send_atom(16'hFFFF, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 1'b1);
    settle();

    // A back-to-back run of full-scale atoms under the widest energy scale,
    // closed by a short random set.
    calm = 1'b1;
    program_scales(32'hFFFF_FFFF, 32'h0000_0100, 1'b0);
    for (int i = 0; i < LONG_SET_ATOMS; i++) begin
      send_atom(16'hFFFF, 24'h800000, 24'h7FFFFF, 24'h800000, 1'b0);
    end
    send_random_set(5);
    settle();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: begin
          e = ket_pkg::ENERGY_SCALE_RESET;
          t = 32'h0000_8000;
        end
        1: begin
          e = 32'd0;
          t = 32'hFFFF_FFFF;
        end
        2: begin
          e = 32'hFFFF_FFFF;
          t = 32'hFFFF_FFFF;
        end
        3: begin
          e = 32'hFFFF_FFFF;
          t = 32'd0;
        end
        4: begin
          e = 32'd1;
          t = 32'd1;
        end
        default: begin
          e = $urandom();
          t = $urandom();
        end
      endcase
      calm = (ph == 5);
      program_scales(e, t, $urandom_range(0, 2) == 0);
      n = 0;
      while (n < PHASE_ATOMS) begin
        len = draw_set_length();
        send_random_set(len);
        n += len;
      end
      settle();
    end

    $display("Checked %0d energy reports from %0d atoms in %0d sets under %0d scale settings.",
             reports_checked, atoms_sent, sets_sent, settings_used);
    $display("The atoms included field extremes and a long run of full-scale atoms.");
    if (mismatches == 0 && reports_pending == 0) begin
      $display("PASS kinetic_energy_tensor_accumulator_top");
    end else begin
      $display("FAIL kinetic_energy_tensor_accumulator_top");
    end
    $finish;
  end

endmodule
